### design/wlm_pkg.sv
// shared types, constants and codes for the window local maximum checker
// used by every module of the block; depends on nothing else
`default_nettype none

package wlm_pkg;

  // storage and window limits
  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 256;
  localparam int MAX_WINDOW = 15;

  // field widths
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_DIM_W = COL_W + 1;
  localparam int ROW_DIM_W = ROW_W + 1;
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int HEIGHT_W = 16;
  localparam int WIN_W    = 4;
  localparam int HALF_W   = $clog2(MAX_WINDOW / 2 + 1);
  localparam int OFF_W    = HALF_W + 1;
  localparam int NULL_W   = 8;

  // queue depths
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = {1'b1, {(HEIGHT_W-1){1'b0}}};

  // register indexes
  typedef enum logic [1:0] {
    REG_COLS,
    REG_ROWS,
    REG_WINDOW,
    REG_NODATA
  } reg_addr_t;

  // command classes
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_DROP
  } op_t;

  // back end states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH,
    BK_POST
  } bk_state_t;

  typedef struct packed {
    op_t                 op;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [HEIGHT_W-1:0] height;
  } cmd_t;

  typedef struct packed {
    logic                is_center_max;
    logic [HEIGHT_W-1:0] max_height;
    logic [NULL_W-1:0]   null_count;
  } res_t;

  typedef struct packed {
    logic [COL_DIM_W-1:0] cols;
    logic [ROW_DIM_W-1:0] rows;
    logic [WIN_W-1:0]     window;
    logic [HEIGHT_W-1:0]  nodata;
  } cfg_t;

endpackage

`default_nettype wire

### design/window_local_max_check.sv
// top level of the window local maximum checker: register port and queues
// depends on wlm_pkg, wlm_front, wlm_back and wlm_res_fifo
`default_nettype none

// Pixel writes and window queries enter through one queue-style input; each
// query gives one result on the output queue, writes give none. A query whose
// window spans s = 2*(window_size/2)+1 cells a side reads its s*s cells in the
// back end through the single read port of the height store: one cell is read
// per cycle, then a compare step and a result step follow. Up to four items wait
// in front of the back end and two results after it. The height store needs no
// clearing; a query must only touch cells that were written before. Registers
// sit at byte addresses 0 (raster_cols), 4 (raster_rows), 8 (window_size),
// 12 (nodata_value) and must be written only while the block is idle.
module window_local_max_check (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                kind,
  input  wire logic [wlm_pkg::COL_W-1:0]           pixel_col,
  input  wire logic [wlm_pkg::ROW_W-1:0]           pixel_row,
  input  wire logic signed [wlm_pkg::HEIGHT_W-1:0] height_value,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic                                     is_center_max,
  output logic signed [wlm_pkg::HEIGHT_W-1:0]      max_height,
  output logic [wlm_pkg::NULL_W-1:0]               null_count,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wlm_pkg::PADDR_W-1:0]         paddr,
  input  wire logic [wlm_pkg::PDATA_W-1:0]         pwdata,
  output logic [wlm_pkg::PDATA_W-1:0]              prdata,
  output logic                                     pready
);
  import wlm_pkg::*;

  cfg_t      cfg;
  reg_addr_t reg_sel;
  logic      reg_wr;

  logic      cmd_valid;
  cmd_t      cmd_head;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  res_t      res_data;
  res_t      res_head;

  assign pready  = 1'b1;
  assign reg_sel = reg_addr_t'(paddr[PADDR_W-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols   <= COL_DIM_W'(MAX_COLS);
      cfg.rows   <= ROW_DIM_W'(MAX_ROWS);
      cfg.window <= WIN_W'(3);
      cfg.nodata <= HEIGHT_MIN;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_COLS:   cfg.cols   <= pwdata[COL_DIM_W-1:0];
        REG_ROWS:   cfg.rows   <= pwdata[ROW_DIM_W-1:0];
        REG_WINDOW: cfg.window <= pwdata[WIN_W-1:0];
        REG_NODATA: cfg.nodata <= pwdata[HEIGHT_W-1:0];
        default:    ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_sel)
      REG_COLS:   prdata = PDATA_W'(cfg.cols);
      REG_ROWS:   prdata = PDATA_W'(cfg.rows);
      REG_WINDOW: prdata = PDATA_W'(cfg.window);
      REG_NODATA: prdata = PDATA_W'(cfg.nodata);
      default:    prdata = '0;
    endcase
  end

  wlm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .height_value (height_value),
    .cmd_valid    (cmd_valid),
    .cmd_head     (cmd_head),
    .cmd_pop      (cmd_pop)
  );

  wlm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  wlm_res_fifo u_res_fifo (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (res_head)
  );

  assign is_center_max = res_head.is_center_max;
  assign max_height    = res_head.max_height;
  assign null_count    = res_head.null_count;

endmodule

`default_nettype wire

### design/wlm_front.sv
// front end: accepts input beats, classifies them and queues the commands
// depends on wlm_pkg
`default_nettype none

module wlm_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         kind,
  input  wire logic [wlm_pkg::COL_W-1:0]    pixel_col,
  input  wire logic [wlm_pkg::ROW_W-1:0]    pixel_row,
  input  wire logic [wlm_pkg::HEIGHT_W-1:0] height_value,
  output logic                              cmd_valid,
  output wlm_pkg::cmd_t                     cmd_head,
  input  wire logic                         cmd_pop
);
  import wlm_pkg::*;

  cmd_t                cmdq [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   count;
  cmd_t                in_cmd;
  logic                do_push;
  logic                do_pop;

  // classify the incoming beat; writes beyond storage are dropped later
  always_comb begin
    in_cmd.col    = pixel_col;
    in_cmd.row    = pixel_row;
    in_cmd.height = height_value;
    if (kind) begin
      in_cmd.op = OP_QUERY;
    end else if (({1'b0, pixel_col} < COL_DIM_W'(MAX_COLS)) &&
                 ({1'b0, pixel_row} < ROW_DIM_W'(MAX_ROWS))) begin
      in_cmd.op = OP_WRITE;
    end else begin
      in_cmd.op = OP_DROP;
    end
  end

  assign full      = (count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd_head  = cmdq[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      cmdq[wr_ptr] <= in_cmd;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/wlm_back.sv
// back end: height store, window scan sequencer and running maximum
// depends on wlm_pkg
`default_nettype none

module wlm_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire wlm_pkg::cfg_t cfg,
  input  wire logic          cmd_valid,
  input  wire wlm_pkg::cmd_t cmd_head,
  output logic               cmd_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output wlm_pkg::res_t      res_data
);
  import wlm_pkg::*;

  bk_state_t state;
  bk_state_t state_next;

  logic [HEIGHT_W-1:0] mem [2**ADDR_W];
  logic [HEIGHT_W-1:0] rdata;

  logic                   mem_we;
  logic                   scan_start;
  logic                   scan_issue;

  logic [COL_DIM_W-1:0]   cols_eff;
  logic [ROW_DIM_W-1:0]   rows_eff;
  logic [HALF_W-1:0]      half;
  logic signed [OFF_W-1:0] half_s;

  logic [COL_W-1:0]       q_col;
  logic [ROW_W-1:0]       q_row;
  logic signed [OFF_W-1:0] dr;
  logic signed [OFF_W-1:0] dc;
  logic                   last_cell;

  logic signed [COL_DIM_W:0] cc;
  logic signed [ROW_DIM_W:0] rr;
  logic                   inb;
  logic [ADDR_W-1:0]      raddr;

  logic                   s1_valid;
  logic                   s1_inb;
  logic                   s1_center;

  logic [HEIGHT_W-1:0]    best;
  logic                   best_center;
  logic [NULL_W-1:0]      nulls;

  // effective limits
  always_comb begin
    cols_eff = (cfg.cols > COL_DIM_W'(MAX_COLS)) ? COL_DIM_W'(MAX_COLS) : cfg.cols;
    rows_eff = (cfg.rows > ROW_DIM_W'(MAX_ROWS)) ? ROW_DIM_W'(MAX_ROWS) : cfg.rows;
    if (int'(cfg.window) > MAX_WINDOW) begin
      half = HALF_W'(MAX_WINDOW / 2);
    end else begin
      half = HALF_W'(cfg.window >> 1);
    end
    half_s = signed'({1'b0, half});
  end

  // cell coordinates and bounds
  always_comb begin
    cc = signed'((COL_DIM_W+1)'(q_col)) + (COL_DIM_W+1)'(dc);
    rr = signed'((ROW_DIM_W+1)'(q_row)) + (ROW_DIM_W+1)'(dr);
    inb = !cc[COL_DIM_W] && !rr[ROW_DIM_W] &&
          (cc[COL_DIM_W-1:0] < cols_eff) && (rr[ROW_DIM_W-1:0] < rows_eff);
    raddr = {rr[ROW_W-1:0], cc[COL_W-1:0]};
    last_cell = (dr == half_s) && (dc == half_s);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && (cmd_head.op == OP_QUERY) && !res_full) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (last_cell) begin
          state_next = BK_FLUSH;
        end
      end
      BK_FLUSH: state_next = BK_POST;
      BK_POST:  state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    scan_start = 1'b0;
    scan_issue = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd_head.op == OP_QUERY) begin
            cmd_pop    = !res_full;
            scan_start = !res_full;
          end else begin
            cmd_pop = 1'b1;
            mem_we  = (cmd_head.op == OP_WRITE);
          end
        end
      end
      BK_SCAN:  scan_issue = 1'b1;
      BK_FLUSH: ;
      BK_POST:  res_push = 1'b1;
      default:  ;
    endcase
  end

  // height store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{cmd_head.row, cmd_head.col}] <= cmd_head.height;
    end
    rdata <= mem[raddr];
  end

  // scan position, row-major from the top left corner
  always_ff @(posedge clk) begin
    if (scan_start) begin
      q_col <= cmd_head.col;
      q_row <= cmd_head.row;
      dr    <= -half_s;
      dc    <= -half_s;
    end else if (scan_issue) begin
      if (dc == half_s) begin
        dc <= -half_s;
        dr <= dr + 1'b1;
      end else begin
        dc <= dc + 1'b1;
      end
    end
  end

  // tag stage alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_inb    <= inb;
    s1_center <= (dr == '0) && (dc == '0);
  end

  // running strict maximum and null count
  always_ff @(posedge clk) begin
    if (scan_start) begin
      best        <= HEIGHT_MIN;
      best_center <= 1'b0;
      nulls       <= '0;
    end else if (s1_valid) begin
      if (!s1_inb || (rdata == cfg.nodata)) begin
        nulls <= nulls + 1'b1;
      end else if ($signed(rdata) > $signed(best)) begin
        best        <= rdata;
        best_center <= s1_center;
      end
    end
  end

  assign res_data.is_center_max = best_center;
  assign res_data.max_height    = best;
  assign res_data.null_count    = nulls;

endmodule

`default_nettype wire

### design/wlm_res_fifo.sv
// result queue between the back end and the result ports
// depends on wlm_pkg
`default_nettype none

module wlm_res_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          res_push,
  input  wire wlm_pkg::res_t res_data,
  output logic               res_full,
  output logic               empty,
  input  wire logic          pop,
  output wlm_pkg::res_t      head
);
  import wlm_pkg::*;

  res_t                  resq [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr;
  logic [RESQ_PTR_W-1:0] rd_ptr;
  logic [RESQ_PTR_W:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign res_full = (count == (RESQ_PTR_W+1)'(RESQ_DEPTH));
  assign empty    = (count == '0);
  assign head     = resq[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  // result storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      resq[wr_ptr] <= res_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/wlm_checker.sv
// port-level checks for the window local maximum checker, bound to the top
// depends on wlm_pkg and window_local_max_check
`default_nettype none

module wlm_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                full,
  input  wire logic                                empty,
  input  wire logic                                pop,
  input  wire logic                                is_center_max,
  input  wire logic signed [wlm_pkg::HEIGHT_W-1:0] max_height,
  input  wire logic [wlm_pkg::NULL_W-1:0]          null_count
);
  import wlm_pkg::*;

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // a window never holds more than the largest square of cells
  a_null_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (int'(null_count) <= MAX_WINDOW * MAX_WINDOW))
    else $error("null count beyond window area");

  // a centre maximum must have beaten the start value
  a_center_beats_min: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_center_max) |-> (max_height != HEIGHT_MIN))
    else $error("centre maximum at minimum height");

  // a waiting beat holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(max_height) && $stable(null_count)))
    else $error("waiting result changed");

endmodule

bind window_local_max_check wlm_checker u_wlm_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .is_center_max (is_center_max),
  .max_height    (max_height),
  .null_count    (null_count)
);

`default_nettype wire

### bench/tb_top.sv
// bench for window_local_max_check: a directed table, then random pixel writes and queries
// keeps its own copy of the height raster and registers to predict each query result
// depends on wlm_pkg and the window_local_max_check top level
module tb_top;
  import wlm_pkg::*;

  localparam int     RANDOM_ITEMS = 1950;
  localparam int     DRAIN_CYCLES = 32;
  localparam int     HOLD_CYCLES  = 1500;
  localparam int     HOT_SPAN     = 24;
  localparam int     DIR_STEPS    = 33;
  localparam longint LIMIT_TIME   = 64'd30_000_000;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum {DS_WRITE, DS_QUERY, DS_CHECKED, DS_CONFIG} dir_op_t;

  typedef struct {
    dir_op_t   op;
    reg_addr_t regi;
    int        col;
    int        row;
    int        value;
    bit        e_center;
    int        e_max;
    int        e_nulls;
  } dir_step_t;

  logic                        clk;
  logic                        rst;
  logic                        push;
  logic                        full;
  logic                        kind;
  logic [COL_W-1:0]            pixel_col;
  logic [ROW_W-1:0]            pixel_row;
  logic signed [HEIGHT_W-1:0]  height_value;
  logic                        empty;
  logic                        pop;
  logic                        is_center_max;
  logic signed [HEIGHT_W-1:0]  max_height;
  logic [NULL_W-1:0]           null_count;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [PADDR_W-1:0]          paddr;
  logic [PDATA_W-1:0]          pwdata;
  logic [PDATA_W-1:0]          prdata;
  logic                        pready;

  // shadow raster and registers
  logic signed [HEIGHT_W-1:0]  height_mem [0:MAX_ROWS*MAX_COLS-1];
  bit                          written_map [0:MAX_ROWS*MAX_COLS-1];
  logic [COL_DIM_W-1:0]        cfg_cols;
  logic [ROW_DIM_W-1:0]        cfg_rows;
  logic [WIN_W-1:0]            cfg_window;
  logic signed [HEIGHT_W-1:0]  cfg_nodata;

  res_t      pending_results [$];
  dir_step_t directed_steps [DIR_STEPS];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        tx_quiet = 0;
  int        rx_quiet = 0;
  int        holds_asked = 0;
  int        holds_done = 0;

  window_local_max_check i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .pixel_col     (pixel_col),
    .pixel_row     (pixel_row),
    .height_value  (height_value),
    .empty         (empty),
    .pop           (pop),
    .is_center_max (is_center_max),
    .max_height    (max_height),
    .null_count    (null_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #(LIMIT_TIME);
    $display("CHECK FAILED");
    $finish;
  end

  // effective raster and window after saturation
  function automatic int eff_cols();
    return (cfg_cols > MAX_COLS) ? MAX_COLS : int'(cfg_cols);
  endfunction

  function automatic int eff_rows();
    return (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
  endfunction

  function automatic int eff_half();
    return ((cfg_window > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_window)) / 2;
  endfunction

  // window scan: strict running maximum, first cell wins a tie
  function automatic res_t predict_query(int c, int r);
    res_t                       res;
    logic signed [HEIGHT_W-1:0] best;
    logic signed [HEIGHT_W-1:0] v;
    int cols, rows, half, cc, rr, dr, dc, bc, br, nulls;
    cols  = eff_cols();
    rows  = eff_rows();
    half  = eff_half();
    best  = HEIGHT_MIN;
    bc    = -1;
    br    = -1;
    nulls = 0;
    for (dr = -half; dr <= half; dr++) begin
      for (dc = -half; dc <= half; dc++) begin
        cc = c + dc;
        rr = r + dr;
        if (cc < 0 || rr < 0 || cc >= cols || rr >= rows) begin
          nulls++;
        end else begin
          v = height_mem[rr*MAX_COLS + cc];
          if (v == cfg_nodata) begin
            nulls++;
          end else if (v > best) begin
            best = v;
            bc   = cc;
            br   = rr;
          end
        end
      end
    end
    res.is_center_max = (bc == c) && (br == r);
    res.max_height    = best;
    res.null_count    = nulls[NULL_W-1:0];
    return res;
  endfunction

  // heights biased towards ties, extremes and the nodata code
  function automatic logic [HEIGHT_W-1:0] pick_height();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'h7fff;
    if (sel == 1) return HEIGHT_MIN;
    if (sel == 2) return cfg_nodata;
    if (sel < 6) return 16'(int'($urandom_range(0, 6)) - 3);
    return 16'($urandom);
  endfunction

  // raster dimension: mostly small, sometimes empty, full or oversized
  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;
    if (sel == 1) return 256;
    if (sel == 2) return $urandom_range(257, 511);
    if (sel < 6) return $urandom_range(1, 256);
    return $urandom_range(1, 16);
  endfunction

  // idle cycles before a beat, with stretches of none
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // one input beat; entered and left at a falling edge
  task automatic send_item(input logic k, input int c, input int r,
                           input logic [HEIGHT_W-1:0] h, input bit typed, input res_t typed_res);
    int gap;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push         <= 1'b1;
    kind         <= k;
    pixel_col    <= c[COL_W-1:0];
    pixel_row    <= r[ROW_W-1:0];
    height_value <= h;
    do @(posedge clk); while (full);
    if (k == KIND_WRITE) begin
      height_mem[r*MAX_COLS + c]  = h;
      written_map[r*MAX_COLS + c] = 1'b1;
    end else begin
      pending_results.push_back(typed ? typed_res : predict_query(c, r));
    end
    items_sent++;
    @(negedge clk);
  endtask

  // query, after writing any raster cell of its window not yet written
  task automatic issue_query(input int c, input int r, input bit typed, input res_t typed_res);
    int cols, rows, half, cc, rr, dr, dc;
    cols = eff_cols();
    rows = eff_rows();
    half = eff_half();
    for (dr = -half; dr <= half; dr++) begin
      for (dc = -half; dc <= half; dc++) begin
        cc = c + dc;
        rr = r + dr;
        if (cc >= 0 && rr >= 0 && cc < cols && rr < rows && !written_map[rr*MAX_COLS + cc])
          send_item(KIND_WRITE, cc, rr, pick_height(), 1'b0, '0);
      end
    end
    send_item(KIND_QUERY, c, r, pick_height(), typed, typed_res);
  endtask

  // all results in, then time for trailing writes to drain
  task automatic wait_idle();
    push <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write: setup then access, then the bus goes idle
  task automatic cfg_write(input reg_addr_t idx, input logic [31:0] value);
    logic [PDATA_W-1:0] data;
    case (idx)
      REG_COLS:   data = PDATA_W'(value[COL_DIM_W-1:0]);
      REG_ROWS:   data = PDATA_W'(value[ROW_DIM_W-1:0]);
      REG_WINDOW: data = PDATA_W'(value[WIN_W-1:0]);
      default:    data = PDATA_W'(value[HEIGHT_W-1:0]);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COLS:   cfg_cols   = data[COL_DIM_W-1:0];
      REG_ROWS:   cfg_rows   = data[ROW_DIM_W-1:0];
      REG_WINDOW: cfg_window = data[WIN_W-1:0];
      default:    cfg_nodata = data[HEIGHT_W-1:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // one random setting and a run of writes and queries under it
  task automatic run_random_phase(input int idx);
    int goal, start, hot_c, hot_r, c, r, sel;
    logic [HEIGHT_W-1:0] nd;
    wait_idle();
    cfg_write(REG_COLS, pick_dim());
    cfg_write(REG_ROWS, pick_dim());
    cfg_write(REG_WINDOW, $urandom_range(0, 15));
    sel = $urandom_range(0, 9);
    if (sel < 5) nd = 16'(int'($urandom_range(0, 6)) - 3);
    else if (sel < 7) nd = HEIGHT_MIN;
    else nd = 16'($urandom);
    cfg_write(REG_NODATA, {16'h0, nd});
    goal  = $urandom_range(100, 220);
    start = items_sent;
    hot_c = (eff_cols() < HOT_SPAN) ? eff_cols() : HOT_SPAN;
    hot_r = (eff_rows() < HOT_SPAN) ? eff_rows() : HOT_SPAN;
    while (items_sent - start < goal) begin
      // one long receiver hold-off so that both queues fill up
      if (idx == 2 && holds_asked == 0 && items_sent - start >= 30) holds_asked = 1;
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < 60) begin
        if (hot_c > 0 && hot_r > 0 && sel < 6) begin
          c = $urandom_range(0, hot_c - 1);
          r = $urandom_range(0, hot_r - 1);
        end else begin
          c = $urandom_range(0, 255);
          r = $urandom_range(0, 255);
        end
        send_item(KIND_WRITE, c, r, pick_height(), 1'b0, '0);
      end else begin
        if (hot_c > 0 && hot_r > 0 && sel < 7) begin
          c = $urandom_range(0, hot_c - 1);
          r = $urandom_range(0, hot_r - 1);
        end else if (sel < 8) begin
          // centres just inside and just outside the raster edge
          c = eff_cols() + int'($urandom_range(0, 3)) - 2;
          r = eff_rows() + int'($urandom_range(0, 3)) - 2;
          if (c < 0) c = 0;
          if (c > 255) c = 255;
          if (r < 0) r = 0;
          if (r > 255) r = 255;
        end else begin
          c = $urandom_range(0, 255);
          r = $urandom_range(0, 255);
        end
        issue_query(c, r, 1'b0, '0);
      end
    end
  endtask

  // compare one result beat with the oldest expectation
  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result: expected none, got centre_max %0b max %0d nulls %0d",
               $time, is_center_max, max_height, null_count);
    end else begin
      want = pending_results[0];
      pending_results.delete(0);
      if (is_center_max !== want.is_center_max) begin
        mismatch_count++;
        $display("%0t: is_center_max expected %0b got %0b", $time, want.is_center_max,
                 is_center_max);
      end
      if (max_height !== want.max_height) begin
        mismatch_count++;
        $display("%0t: max_height expected %0d got %0d", $time, $signed(want.max_height),
                 max_height);
      end
      if (null_count !== want.null_count) begin
        mismatch_count++;
        $display("%0t: null_count expected %0d got %0d", $time, want.null_count, null_count);
      end
    end
  endtask

  // result side
  initial begin
    int stall;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holds_done < holds_asked) begin
        holds_done++;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = draw_gap(rx_quiet);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_result();
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    dir_step_t s;
    res_t      typed;
    int        i;
    int        phase;
    int        random_start;
    rst          = 1'b1;
    push         = 1'b0;
    kind         = KIND_WRITE;
    pixel_col    = '0;
    pixel_row    = '0;
    height_value = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cfg_cols     = 9'd256;
    cfg_rows     = 9'd256;
    cfg_window   = 4'd3;
    cfg_nodata   = HEIGHT_MIN;

    // reset setting: 256x256, 3x3 window, nodata at the minimum height
    directed_steps = '{
      '{DS_WRITE,   REG_COLS,   0,   0,      100, 0,      0,   0},
      '{DS_WRITE,   REG_COLS,   1,   0,       50, 0,      0,   0},
      '{DS_WRITE,   REG_COLS,   0,   1,   -32768, 0,      0,   0},
      '{DS_WRITE,   REG_COLS,   1,   1,      100, 0,      0,   0},
      '{DS_QUERY,   REG_COLS,   0,   0,        0, 1,    100,   6},
      '{DS_WRITE,   REG_COLS, 254, 254,    32767, 0,      0,   0},
      '{DS_WRITE,   REG_COLS, 255, 254,   -32767, 0,      0,   0},
      '{DS_WRITE,   REG_COLS, 254, 255,        0, 0,      0,   0},
      '{DS_WRITE,   REG_COLS, 255, 255,    32767, 0,      0,   0},
      '{DS_QUERY,   REG_COLS, 255, 255,        0, 0,  32767,   5},
      '{DS_CHECKED, REG_COLS,   1,   1,        0, 0,      0,   0},
      // empty raster
      '{DS_CONFIG,  REG_COLS,   0,   0,        0, 0,      0,   0},
      '{DS_QUERY,   REG_COLS,   5,   5,        0, 0, -32768,   9},
      // oversized columns, two rows, single-cell window
      '{DS_CONFIG,  REG_COLS,   0,   0,      511, 0,      0,   0},
      '{DS_CONFIG,  REG_ROWS,   0,   0,        2, 0,      0,   0},
      '{DS_CONFIG,  REG_WINDOW, 0,   0,        0, 0,      0,   0},
      '{DS_QUERY,   REG_COLS,   0,   0,        0, 1,    100,   0},
      '{DS_QUERY,   REG_COLS,   1,   1,        0, 1,    100,   0},
      '{DS_QUERY,   REG_COLS,   0,   5,        0, 0, -32768,   1},
      // 2x2 raster, widest window, nodata hit inside
      '{DS_CONFIG,  REG_COLS,   0,   0,        2, 0,      0,   0},
      '{DS_CONFIG,  REG_NODATA, 0,   0,       50, 0,      0,   0},
      '{DS_CONFIG,  REG_WINDOW, 0,   0,       15, 0,      0,   0},
      '{DS_WRITE,   REG_COLS, 200, 200,        7, 0,      0,   0},
      '{DS_QUERY,   REG_COLS,   0,   0,        0, 1,    100, 222},
      // minimum height as a valid cell never wins
      '{DS_CONFIG,  REG_NODATA, 0,   0,        0, 0,      0,   0},
      '{DS_CONFIG,  REG_WINDOW, 0,   0,        1, 0,      0,   0},
      '{DS_QUERY,   REG_COLS,   0,   1,        0, 0, -32768,   0},
      // write made outside the raster in use is kept
      '{DS_CONFIG,  REG_COLS,   0,   0,      256, 0,      0,   0},
      '{DS_CONFIG,  REG_ROWS,   0,   0,      256, 0,      0,   0},
      '{DS_QUERY,   REG_COLS, 200, 200,        0, 1,      7,   0},
      // even window size
      '{DS_CONFIG,  REG_WINDOW, 0,   0,        2, 0,      0,   0},
      '{DS_CHECKED, REG_COLS, 254, 254,        0, 0,      0,   0},
      '{DS_CHECKED, REG_COLS, 255,   0,        0, 0,      0,   0}
    };

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (i = 0; i < DIR_STEPS; i++) begin
      s = directed_steps[i];
      typed.is_center_max = s.e_center;
      typed.max_height    = s.e_max[HEIGHT_W-1:0];
      typed.null_count    = s.e_nulls[NULL_W-1:0];
      case (s.op)
        DS_WRITE: begin
          send_item(KIND_WRITE, s.col, s.row, s.value[HEIGHT_W-1:0], 1'b0, '0);
        end
        DS_QUERY: begin
          issue_query(s.col, s.row, 1'b1, typed);
        end
        DS_CHECKED: begin
          issue_query(s.col, s.row, 1'b0, '0);
        end
        default: begin
          wait_idle();
          cfg_write(s.regi, s.value);
        end
      endcase
    end

    // random phases
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      run_random_phase(phase);
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
